/* rtl/m4vt_pkg.sv */
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants of the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
package m4vt_pkg;

    // Fixed-point format of vector components and matrix entries.
    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int NCOMP     = 4;
    localparam int VEC_W     = COMP_W * NCOMP;

    // Internal arithmetic widths: exact products, pair sums, four-term sum.
    localparam int PROD_W = 2 * COMP_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Configuration port geometry: eight 64-bit registers at 8-byte spacing.
    localparam int NREGS    = 8;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int ADDR_LSB = 3;
    localparam int IDX_W    = 3;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic [NCOMP-1:0][COMP_W-1:0] t_vec;
    typedef logic [NCOMP-1:0][NCOMP-1:0][COMP_W-1:0] t_mat;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic adv_mul;
        logic adv_pair;
        logic adv_out;
    } t_stage_ctl;

    localparam logic [COMP_W-1:0] ONE_Q  = COMP_W'(1) << FRAC_BITS;
    localparam logic [COMP_W-1:0] SAT_HI = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] SAT_LO = {1'b1, {(COMP_W-1){1'b0}}};

endpackage

/* rtl/matrix4_vector_transform.sv */
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Streams 4D row vectors through a configurable 4x4 matrix in Q16.16.
//
// Each input transaction carries one vector (x, y, z, w), signed Q16.16,
// packed into s_axis_tdata with x in the lowest 32 bits. The block returns
// the vector times the row-major matrix held in eight 64-bit APB registers
// (register 2*R holds M[R][0] low and M[R][1] high, register 2*R+1 holds
// M[R][2] low and M[R][3] high, at byte address 8*index). Each component
// is the exact sum of four products, rounded to nearest with ties toward
// plus infinity and saturated to 32 bits; m_axis_tuser flags a result in
// which any component saturated, and tlast passes through unchanged. After
// reset the matrix is the identity. The datapath is a three-stage pipeline
// (16 parallel 32x32 multipliers, a pair-add stage, and a final add with
// rounding and saturation that feeds the output register); one transaction
// is taken every cycle while the output is not stalled. Each stage holds
// when the next one is full and stalled; empty stages fill up while the
// output waits, so s_axis_tready drops only when all three stages hold
// data. Registers must be written only while no transaction is in flight;
// the block itself does not enforce this. There is no other state.
// ----------------------------------------------------------------------------
module matrix4_vector_transform (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream. tdata fields from bit 0 up: in_x, in_y, in_z, in_w.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [m4vt_pkg::VEC_W-1:0]   s_axis_tdata,
    input  logic                         s_axis_tlast,
    // Output stream. tdata fields from bit 0 up: out_x, out_y, out_z, out_w.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [m4vt_pkg::VEC_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast,
    // tuser fields from bit 0 up: clipped.
    output logic                         m_axis_tuser,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [m4vt_pkg::ADDR_W-1:0]  paddr,
    input  logic [m4vt_pkg::REG_W-1:0]   pwdata,
    output logic [m4vt_pkg::REG_W-1:0]   prdata,
    output logic                         pready
);
    import m4vt_pkg::*;

    t_mat       mat;
    t_vec       vec_in;
    t_stage_ctl ctl;
    t_vec       res;
    logic [NCOMP-1:0] clip;

    // Valid and last bits travel alongside the three datapath stages.
    logic r_v_mul, r_v_pair, r_v_out;
    logic r_l_mul, r_l_pair, r_l_out;
    logic n_v_mul, n_v_pair, n_v_out;

    m4vt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mat   (mat)
    );

    assign vec_in = s_axis_tdata;

    // A stage loads when it is empty or its content moves on this cycle.
    assign ctl.adv_out  = ~r_v_out | m_axis_tready;
    assign ctl.adv_pair = ~r_v_pair | ctl.adv_out;
    assign ctl.adv_mul  = ~r_v_mul | ctl.adv_pair;
    assign s_axis_tready = ctl.adv_mul;

    assign n_v_mul  = ctl.adv_mul  ? s_axis_tvalid : r_v_mul;
    assign n_v_pair = ctl.adv_pair ? r_v_mul       : r_v_pair;
    assign n_v_out  = ctl.adv_out  ? r_v_pair      : r_v_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul  <= 1'b0;
            r_v_pair <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_v_mul  <= n_v_mul;
            r_v_pair <= n_v_pair;
            r_v_out  <= n_v_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv_mul) begin
            r_l_mul <= s_axis_tlast;
        end
        if (ctl.adv_pair) begin
            r_l_pair <= r_l_mul;
        end
        if (ctl.adv_out) begin
            r_l_out <= r_l_pair;
        end
    end

    // One column unit per output component; unit j sees column j of M.
    for (genvar j = 0; j < NCOMP; j++) begin : g_col
        t_vec col;
        for (genvar i = 0; i < NCOMP; i++) begin : g_ent
            assign col[i] = mat[i][j];
        end
        m4vt_column u_column (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_vec  (vec_in),
            .i_col  (col),
            .o_res  (res[j]),
            .o_clip (clip[j])
        );
    end

    assign m_axis_tvalid = r_v_out;
    assign m_axis_tdata  = res;
    assign m_axis_tlast  = r_l_out;
    assign m_axis_tuser  = |clip;

    // Input backpressure only when every stage is occupied.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v_mul && r_v_pair && r_v_out))
        else $error("input blocked while a pipeline stage is empty");

    // An accepted transaction lands in the multiply stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v_mul)
        else $error("accepted transaction lost at multiply stage");

    // A held pair stage keeps its transaction and its last flag.
    a_pair_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v_pair && !ctl.adv_pair) |=> (r_v_pair && $stable(r_l_pair)))
        else $error("pair stage changed while stalled");

    // A clipped result carries at least one saturated component.
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (res[0] == SAT_HI || res[0] == SAT_LO || res[1] == SAT_HI ||
             res[1] == SAT_LO || res[2] == SAT_HI || res[2] == SAT_LO ||
             res[3] == SAT_HI || res[3] == SAT_LO))
        else $error("clip flag set without a saturated component");

endmodule

/* rtl/m4vt_regs.sv */
// ----------------------------------------------------------------------------
// m4vt_regs
// APB register file holding the row-major 4x4 matrix, reset to identity.
// ----------------------------------------------------------------------------
module m4vt_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [m4vt_pkg::ADDR_W-1:0]  paddr,
    input  logic [m4vt_pkg::REG_W-1:0]   pwdata,
    output logic [m4vt_pkg::REG_W-1:0]   prdata,
    output logic                         pready,
    output m4vt_pkg::t_mat               o_mat
);
    import m4vt_pkg::*;

    logic [REG_W-1:0] r_mat [NREGS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_LSB +: IDX_W];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = r_mat[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= {{COMP_W{1'b0}}, ONE_Q};
            r_mat[1] <= '0;
            r_mat[2] <= {ONE_Q, {COMP_W{1'b0}}};
            r_mat[3] <= '0;
            r_mat[4] <= '0;
            r_mat[5] <= {{COMP_W{1'b0}}, ONE_Q};
            r_mat[6] <= '0;
            r_mat[7] <= {ONE_Q, {COMP_W{1'b0}}};
        end else if (wr_en) begin
            r_mat[idx] <= pwdata;
        end
    end

    // Entry (row, col) sits in register 2*row + col/2, half col%2.
    always_comb begin
        for (int r = 0; r < NCOMP; r++) begin
            for (int c = 0; c < NCOMP; c++) begin
                o_mat[r][c] = r_mat[IDX_W'(2*r + c/2)][COMP_W*(c%2) +: COMP_W];
            end
        end
    end

endmodule

/* rtl/m4vt_column.sv */
// ----------------------------------------------------------------------------
// m4vt_column
// Three-stage dot product of one matrix column: multiply, pair add,
// final add with rounding and saturation.
// ----------------------------------------------------------------------------
module m4vt_column (
    input  logic                 i_clk,
    input  m4vt_pkg::t_stage_ctl i_ctl,
    input  m4vt_pkg::t_vec       i_vec,
    input  m4vt_pkg::t_vec       i_col,
    output m4vt_pkg::t_comp      o_res,
    output logic                 o_clip
);
    import m4vt_pkg::*;

    localparam int SH_W = SUM_W - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod [NCOMP];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [COMP_W-1:0] r_res;
    logic                     r_clip;

    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [SH_W-1:0]   quo;
    logic                     fits;
    logic signed [COMP_W-1:0] n_res;
    logic                     n_clip;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_mul) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_prod[i] <= $signed(i_vec[i]) * $signed(i_col[i]);
            end
        end
        if (i_ctl.adv_pair) begin
            r_pair[0] <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
            r_pair[1] <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
        end
        if (i_ctl.adv_out) begin
            r_res  <= n_res;
            r_clip <= n_clip;
        end
    end

    // Adding half an LSB and flooring rounds ties toward plus infinity.
    always_comb begin
        sum_rnd = SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]) + RND;
        quo     = sum_rnd[SUM_W-1:FRAC_BITS];
        fits    = (&quo[SH_W-1:COMP_W-1]) | ~(|quo[SH_W-1:COMP_W-1]);
        n_clip  = ~fits;
        if (fits) begin
            n_res = quo[COMP_W-1:0];
        end else if (quo[SH_W-1]) begin
            n_res = SAT_LO;
        end else begin
            n_res = SAT_HI;
        end
    end

    assign o_res  = r_res;
    assign o_clip = r_clip;

endmodule
